// File: sv/swd_pkg.sv
// Shared types and constants for the SWD master transfer engine.
// No dependencies; imported by swd_master_transfer_engine.
package swd_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgW     = 8;

  localparam logic [7:0]  LresetDefault = 8'd60;
  localparam logic [7:0]  LresetMin     = 8'd50;
  localparam logic [15:0] SwitchSeq     = 16'hE79E;

  localparam logic [2:0] AckOk   = 3'b001;
  localparam logic [2:0] AckWait = 3'b010;

  localparam logic [1:0] ModeTick     = 2'd0;
  localparam logic [1:0] ModeTransfer = 2'd1;
  localparam logic [1:0] ModeSwitch   = 2'd2;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatWait   = 2'd1;
  localparam logic [1:0] StatFault  = 2'd2;
  localparam logic [1:0] StatParity = 2'd3;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhReq     = 4'd1,
    PhTurnR   = 4'd2,
    PhAck     = 4'd3,
    PhRdata   = 4'd4,
    PhTurnW   = 4'd5,
    PhWdata   = 4'd6,
    PhTurnEnd = 4'd7,
    PhIdleEnd = 4'd8,
    PhLreset1 = 4'd9,
    PhSeq16   = 4'd10,
    PhLreset2 = 4'd11,
    PhIdle2   = 4'd12
  } phase_e;

endpackage

// File: sv/swd_master_transfer_engine.sv
// SWD master transfer engine: one input word per SWCLK bit period.
// Depends on swd_pkg for phase codes and protocol constants.
// A result word is valid in the cycle after its input word is accepted.
// One word per cycle while the output is not stalled; a single result register sits between the
// state logic and the output, and input is taken whenever it is empty or drained.
// Reset: asynchronous, active low; phase returns to idle, line reset length to 60.
module swd_master_transfer_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [swd_pkg::CfgW-1:0]      cfg_wr_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [0] use_ap, [1] read_not_write, [3:2] reg_addr, [35:4] write_data, [36] swdio_in
  input  logic [swd_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [1:0] mode
  input  logic [swd_pkg::InUserW-1:0]   s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] swdio_out, [1] swdio_drive, [2] busy_res, [3] done_res, [5:4] status,
  // [37:6] read_data
  output logic [swd_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import swd_pkg::*;

  logic [7:0]  lreset_q;
  phase_e      phase_q, phase_d, ph_s;
  logic [7:0]  bc_q, bc_d, bc_s;
  logic [31:0] sw_q, sw_d, sw_s;
  logic        par_q, par_d, par_s;
  logic [3:0]  rl_q, rl_d, rl_s;
  logic [2:0]  ack_q, ack_d, ack_s;
  logic [1:0]  rs_q, rs_d, rs_s;

  logic        out_vld_q;
  logic [37:0] out_q, out_d;

  logic [1:0]  mode;
  logic        din;
  logic        accept;
  logic [7:0]  lreset_len;
  logic [2:0]  ack_new;
  logic [1:0]  req_idx;

  assign mode       = s_axis_tuser_i[1:0];
  assign din        = s_axis_tdata_i[36];
  assign lreset_len = (lreset_q < LresetMin) ? LresetMin : lreset_q;
  assign ack_new    = ack_s | (din ? (3'b001 << bc_s[1:0]) : 3'b000);
  assign req_idx    = bc_s[1:0] - 2'd1;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

  // start handling: state as seen by this cycle's bit
  always_comb begin
    ph_s  = phase_q;
    bc_s  = bc_q;
    sw_s  = sw_q;
    par_s = par_q;
    rl_s  = rl_q;
    ack_s = ack_q;
    rs_s  = rs_q;
    if (phase_q == PhIdle) begin
      if (mode == ModeTransfer) begin
        rl_s  = s_axis_tdata_i[3:0];
        sw_s  = s_axis_tdata_i[35:4];
        ack_s = 3'b000;
        par_s = 1'b0;
        rs_s  = StatOk;
        bc_s  = 8'd0;
        ph_s  = PhReq;
      end else if (mode == ModeSwitch) begin
        bc_s = 8'd0;
        rs_s = StatOk;
        ph_s = PhLreset1;
      end
    end
  end

  // next state
  always_comb begin
    phase_d = ph_s;
    bc_d    = bc_s;
    sw_d    = sw_s;
    par_d   = par_s;
    rl_d    = rl_s;
    ack_d   = ack_s;
    rs_d    = rs_s;
    case (ph_s)
      PhReq: begin
        if (bc_s >= 8'd7) begin
          phase_d = PhTurnR;
          bc_d    = 8'd0;
        end else begin
          bc_d = bc_s + 8'd1;
        end
      end
      PhTurnR: begin
        phase_d = PhAck;
        bc_d    = 8'd0;
      end
      PhAck: begin
        ack_d = ack_new;
        if (bc_s >= 8'd2) begin
          bc_d  = 8'd0;
          par_d = 1'b0;
          if (ack_new == AckOk) begin
            if (rl_s[1]) begin
              sw_d    = '0;
              phase_d = PhRdata;
            end else begin
              phase_d = PhTurnW;
            end
          end else begin
            rs_d    = (ack_new == AckWait) ? StatWait : StatFault;
            phase_d = PhTurnEnd;
          end
        end else begin
          bc_d = bc_s + 8'd1;
        end
      end
      PhRdata: begin
        if (bc_s < 8'd32) begin
          sw_d[bc_s[4:0]] = sw_s[bc_s[4:0]] | din;
          par_d           = par_s ^ din;
          bc_d            = bc_s + 8'd1;
        end else begin
          rs_d    = (par_s != din) ? StatParity : StatOk;
          phase_d = PhTurnEnd;
          bc_d    = 8'd0;
        end
      end
      PhTurnW: begin
        phase_d = PhWdata;
        bc_d    = 8'd0;
        par_d   = 1'b0;
      end
      PhWdata: begin
        if (bc_s < 8'd32) begin
          par_d = par_s ^ sw_s[bc_s[4:0]];
          bc_d  = bc_s + 8'd1;
        end else begin
          rs_d    = StatOk;
          phase_d = PhIdleEnd;
          bc_d    = 8'd0;
        end
      end
      PhTurnEnd: begin
        phase_d = PhIdleEnd;
      end
      PhIdleEnd: begin
        phase_d = PhIdle;
        bc_d    = 8'd0;
      end
      PhLreset1, PhLreset2: begin
        if (({1'b0, bc_s} + 9'd1) >= {1'b0, lreset_len}) begin
          phase_d = (ph_s == PhLreset1) ? PhSeq16 : PhIdle2;
          bc_d    = 8'd0;
        end else begin
          bc_d = bc_s + 8'd1;
        end
      end
      PhSeq16: begin
        if (bc_s >= 8'd15) begin
          phase_d = PhLreset2;
          bc_d    = 8'd0;
        end else begin
          bc_d = bc_s + 8'd1;
        end
      end
      PhIdle2: begin
        if (bc_s >= 8'd1) begin
          phase_d = PhIdle;
          bc_d    = 8'd0;
        end else begin
          bc_d = bc_s + 8'd1;
        end
      end
      default: begin
        phase_d = PhIdle;
        bc_d    = 8'd0;
      end
    endcase
  end

  // result word
  always_comb begin
    logic        o_val, o_drv, o_busy, o_done;
    logic [1:0]  o_stat;
    logic [31:0] o_data;
    o_val  = 1'b0;
    o_drv  = 1'b1;
    o_busy = 1'b1;
    o_done = 1'b0;
    o_stat = StatOk;
    o_data = '0;
    case (ph_s)
      PhReq: begin
        if (bc_s == 8'd0 || bc_s == 8'd7) begin
          o_val = 1'b1;
        end else if (bc_s == 8'd6) begin
          o_val = 1'b0;
        end else if (bc_s == 8'd5) begin
          o_val = ^rl_s;
        end else begin
          o_val = rl_s[req_idx];
        end
      end
      PhTurnR, PhAck, PhRdata, PhTurnW, PhTurnEnd: begin
        o_drv = 1'b0;
      end
      PhWdata: begin
        o_val = (bc_s < 8'd32) ? sw_s[bc_s[4:0]] : par_s;
      end
      PhIdleEnd: begin
        o_done = 1'b1;
        o_stat = rs_s;
        if (rs_s == StatOk && rl_s[1]) begin
          o_data = sw_s;
        end
      end
      PhLreset1, PhLreset2: begin
        o_val = 1'b1;
      end
      PhSeq16: begin
        o_val = SwitchSeq[bc_s[3:0]];
      end
      PhIdle2: begin
        o_done = (bc_s >= 8'd1);
      end
      default: begin
        o_busy = 1'b0;
      end
    endcase
    out_d = {o_data, o_stat, o_done, o_busy, o_drv, o_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lreset_q <= LresetDefault;
    end else if (cfg_wr_en_i) begin
      lreset_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      bc_q      <= '0;
      sw_q      <= '0;
      par_q     <= 1'b0;
      rl_q      <= '0;
      ack_q     <= '0;
      rs_q      <= StatOk;
      out_vld_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      bc_q      <= bc_d;
      sw_q      <= sw_d;
      par_q     <= par_d;
      rl_q      <= rl_d;
      ack_q     <= ack_d;
      rs_q      <= rs_d;
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking bench for swd_master_transfer_engine: drives SWCLK words, models the
// engine bit by bit and compares every result word. Depends on swd_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import swd_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef struct {
    logic        swdio_out;
    logic        swdio_drive;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [31:0] read_data;
  } line_state_t;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CfgW-1:0]     cfg_wr_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic [InUserW-1:0]  s_user = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  swd_master_transfer_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  line_state_t line_states_q[$];
  int unsigned fail_count = 0;
  int unsigned reports    = 0;
  int unsigned words_sent = 0;
  int unsigned stall      = 0;
  bit          steady     = 1'b0;

  phase_e      sw_phase = PhIdle;
  logic [7:0]  sw_cnt   = '0;
  logic [31:0] sw_shift = '0;
  logic        sw_par   = 1'b0;
  logic [3:0]  sw_req   = '0;
  logic [2:0]  sw_ack   = '0;
  logic [1:0]  sw_stat  = StatOk;
  logic [7:0]  sw_lrc   = LresetDefault;

  function automatic line_state_t swd_bit_cycle(logic [1:0] mode, logic ap, logic rnw,
                                                logic [1:0] addr, logic [31:0] wd,
                                                logic din);
    line_state_t o;
    logic [7:0]  lr_len;
    o.swdio_out   = 1'b0;
    o.swdio_drive = 1'b1;
    o.busy        = 1'b1;
    o.done        = 1'b0;
    o.status      = StatOk;
    o.read_data   = '0;
    lr_len = (sw_lrc < LresetMin) ? LresetMin : sw_lrc;
    if (sw_phase == PhIdle) begin
      if (mode == ModeTransfer) begin
        sw_req   = {addr, rnw, ap};
        sw_shift = wd;
        sw_ack   = '0;
        sw_par   = 1'b0;
        sw_stat  = StatOk;
        sw_cnt   = '0;
        sw_phase = PhReq;
      end else if (mode == ModeSwitch) begin
        sw_cnt   = '0;
        sw_stat  = StatOk;
        sw_phase = PhLreset1;
      end
    end
    case (sw_phase)
      PhReq: begin
        if (sw_cnt == 0 || sw_cnt == 7) o.swdio_out = 1'b1;
        else if (sw_cnt == 6) o.swdio_out = 1'b0;
        else if (sw_cnt == 5) o.swdio_out = ^sw_req;
        else o.swdio_out = sw_req[sw_cnt[1:0] - 2'd1];
        if (sw_cnt >= 7) begin
          sw_phase = PhTurnR;
          sw_cnt   = '0;
        end else sw_cnt++;
      end
      PhTurnR: begin
        o.swdio_drive = 1'b0;
        sw_phase = PhAck;
        sw_cnt   = '0;
      end
      PhAck: begin
        o.swdio_drive = 1'b0;
        sw_ack = sw_ack | (3'(din) << sw_cnt[1:0]);
        if (sw_cnt >= 2) begin
          sw_cnt = '0;
          sw_par = 1'b0;
          if (sw_ack == AckOk) begin
            if (sw_req[1]) begin
              sw_shift = '0;
              sw_phase = PhRdata;
            end else sw_phase = PhTurnW;
          end else begin
            sw_stat  = (sw_ack == AckWait) ? StatWait : StatFault;
            sw_phase = PhTurnEnd;
          end
        end else sw_cnt++;
      end
      PhRdata: begin
        o.swdio_drive = 1'b0;
        if (sw_cnt < 32) begin
          sw_shift = sw_shift | (32'(din) << sw_cnt[4:0]);
          sw_par   = sw_par ^ din;
          sw_cnt++;
        end else begin
          sw_stat  = (sw_par != din) ? StatParity : StatOk;
          sw_phase = PhTurnEnd;
          sw_cnt   = '0;
        end
      end
      PhTurnW: begin
        o.swdio_drive = 1'b0;
        sw_phase = PhWdata;
        sw_cnt   = '0;
        sw_par   = 1'b0;
      end
      PhWdata: begin
        if (sw_cnt < 32) begin
          o.swdio_out = sw_shift[sw_cnt[4:0]];
          sw_par = sw_par ^ sw_shift[sw_cnt[4:0]];
          sw_cnt++;
        end else begin
          o.swdio_out = sw_par;
          sw_stat  = StatOk;
          sw_phase = PhIdleEnd;
          sw_cnt   = '0;
        end
      end
      PhTurnEnd: begin
        o.swdio_drive = 1'b0;
        sw_phase = PhIdleEnd;
      end
      PhIdleEnd: begin
        o.done   = 1'b1;
        o.status = sw_stat;
        if (sw_stat == StatOk && sw_req[1]) o.read_data = sw_shift;
        sw_phase = PhIdle;
        sw_cnt   = '0;
      end
      PhLreset1, PhLreset2: begin
        o.swdio_out = 1'b1;
        if (int'(sw_cnt) + 1 >= int'(lr_len)) begin
          sw_phase = (sw_phase == PhLreset1) ? PhSeq16 : PhIdle2;
          sw_cnt   = '0;
        end else sw_cnt++;
      end
      PhSeq16: begin
        o.swdio_out = SwitchSeq[sw_cnt[3:0]];
        if (sw_cnt >= 15) begin
          sw_phase = PhLreset2;
          sw_cnt   = '0;
        end else sw_cnt++;
      end
      PhIdle2: begin
        if (sw_cnt >= 1) begin
          o.done   = 1'b1;
          sw_phase = PhIdle;
          sw_cnt   = '0;
        end else sw_cnt++;
      end
      default: begin
        sw_phase = PhIdle;
        sw_cnt   = '0;
        o.busy   = 1'b0;
      end
    endcase
    return o;
  endfunction

  task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      reports++;
      if (reports <= 10) $display("mismatch %s: expected %h, got %h", fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    line_state_t want;
    if (rst_n && m_valid && m_ready) begin
      if (line_states_q.size() == 0) begin
        fail_count++;
        reports++;
        if (reports <= 10) $display("unexpected result word %h", m_data);
      end else begin
        want = line_states_q.pop_front();
        compare_field("swdio_out", 32'(want.swdio_out), 32'(m_data[0]));
        compare_field("swdio_drive", 32'(want.swdio_drive), 32'(m_data[1]));
        compare_field("busy", 32'(want.busy), 32'(m_data[2]));
        compare_field("done", 32'(want.done), 32'(m_data[3]));
        compare_field("status", 32'(want.status), 32'(m_data[5:4]));
        compare_field("read_data", want.read_data, m_data[37:6]);
      end
    end
  end

  always @(posedge clk_i) begin
    m_ready <= steady || ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) stall <= 0;
    else if (stall >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles", stall);
      $display("Verification failed");
      $finish;
    end else stall <= stall + 1;
  end

  task automatic send_word(logic [1:0] mode, logic ap, logic rnw, logic [1:0] addr,
                           logic [31:0] wd, logic din);
    while (!steady && $urandom_range(99) < 14) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= {3'b000, din, wd, addr, rnw, ap};
    do @(posedge clk_i); while (!s_ready);
    line_states_q.push_back(swd_bit_cycle(mode, ap, rnw, addr, wd, din));
    words_sent++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (line_states_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_line_reset(logic [7:0] value);
    drain_results();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    sw_lrc = value;
  endtask

  task automatic finish_seq();
    while (sw_phase != PhIdle)
      send_word(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
  endtask

  task automatic run_transfer(logic ap, logic rnw, logic [1:0] addr, logic [31:0] wd,
                              logic [2:0] ack, logic [31:0] rd, bit bad_par);
    logic din;
    send_word(ModeTransfer, ap, rnw, addr, wd, 1'($urandom_range(1)));
    while (sw_phase != PhIdle) begin
      if (sw_phase == PhAck) din = ack[sw_cnt[1:0]];
      else if (sw_phase == PhRdata) din = (sw_cnt < 32) ? rd[sw_cnt[4:0]] : (^rd) ^ bad_par;
      else din = 1'($urandom_range(1));
      send_word(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                2'($urandom_range(3)), $urandom, din);
    end
  endtask

  task automatic run_switch();
    send_word(ModeSwitch, 1'($urandom_range(1)), 1'($urandom_range(1)),
              2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
    finish_seq();
  endtask

  task automatic test_idle_ticks();
    send_word(ModeTick, 1'b0, 1'b0, 2'd0, 32'h0000_0000, 1'b0);
    send_word(2'd3, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1);
    send_word(ModeTick, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1);
    send_word(2'd3, 1'b0, 1'b0, 2'd0, 32'h0000_0000, 1'b0);
  endtask

  task automatic test_write_transfers();
    run_transfer(1'b0, 1'b0, 2'd0, 32'h0000_0000, AckOk, '0, 1'b0);
    run_transfer(1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, AckOk, '0, 1'b0);
    run_transfer(1'b1, 1'b0, 2'd2, 32'hA5A5_5A5B, AckOk, '0, 1'b0);
  endtask

  task automatic test_read_transfers();
    run_transfer(1'b0, 1'b1, 2'd1, $urandom, AckOk, 32'hFFFF_FFFF, 1'b0);
    run_transfer(1'b1, 1'b1, 2'd2, $urandom, AckOk, 32'h0000_0000, 1'b0);
    run_transfer(1'b1, 1'b1, 2'd3, $urandom, AckOk, 32'h1234_5679, 1'b0);
    run_transfer(1'b0, 1'b1, 2'd3, $urandom, AckOk, 32'h1234_5678, 1'b1);
  endtask

  task automatic test_ack_responses();
    run_transfer(1'b0, 1'b0, 2'd1, $urandom, AckWait, '0, 1'b0);
    run_transfer(1'b1, 1'b1, 2'd0, $urandom, AckWait, $urandom, 1'b0);
    run_transfer(1'b0, 1'b1, 2'd2, $urandom, 3'b100, $urandom, 1'b0);
    run_transfer(1'b1, 1'b0, 2'd3, $urandom, 3'b000, '0, 1'b0);
    run_transfer(1'b0, 1'b1, 2'd1, $urandom, 3'b111, $urandom, 1'b0);
  endtask

  task automatic test_switch_sequence();
    run_switch();
    run_transfer(1'b0, 1'b1, 2'd0, $urandom, AckOk, $urandom, 1'b0);
    write_line_reset(8'd0);
    run_switch();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    logic [2:0]  ack;
    bit          paused;
    paused = 1'b0;
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: write_line_reset(LresetMin);
        1: write_line_reset(8'($urandom_range(254, 51)));
        default: write_line_reset(8'($urandom_range(49, 0)));
      endcase
      steady = (seg == 1);
      start  = words_sent;
      while (words_sent - start < 30) begin
        if (seg == 1 && !paused && words_sent - start >= 15) begin
          paused = 1'b1;
          drain_results();
        end
        pick = $urandom_range(99);
        if (pick < 75) begin
          ack = ($urandom_range(99) < 70) ? AckOk : 3'($urandom_range(7));
          run_transfer(1'($urandom_range(1)), 1'($urandom_range(1)),
                       2'($urandom_range(3)), $urandom, ack, $urandom,
                       $urandom_range(99) < 15);
        end else if (pick < 80) begin
          run_switch();
        end else begin
          send_word(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
          finish_seq();
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_write_transfers();
    test_read_transfers();
    test_ack_responses();
    test_switch_sequence();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (line_states_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
